// ===== hw/rtl/mbrlr_pkg.sv =====
`timescale 1ns / 1ps
package mbrlr_pkg;

	// table size default
	localparam int SLOTS_DEF = 8;

	// stream field widths
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 72;

	// command codes carried on the input tuser
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_SLOT = 3'd1;
	localparam logic [2:0] ST_UNUSED   = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_RDONLY   = 3'd4;
	localparam logic [2:0] ST_BAD_SIG  = 3'd5;
	localparam logic [2:0] ST_NONE     = 3'd6;

	// result kinds
	localparam logic KIND_SCAN   = 1'b0;
	localparam logic KIND_ACCESS = 1'b1;

	// boot record layout
	localparam logic [8:0] ENTRY_BASE  = 9'd446;
	localparam logic [8:0] ENTRY_END   = 9'd510;
	localparam logic [8:0] SIG_POS     = 9'd510;
	localparam logic [8:0] RECORD_LAST = 9'd511;
	localparam logic [7:0] SIG_FIRST   = 8'h55;
	localparam logic [7:0] SIG_SECOND  = 8'hAA;
	localparam logic [7:0] TYPE_EMPTY  = 8'h00;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PLACE,
		ST_REQ_RD,
		ST_REQ_CHK
	} state_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_BAD_SIG,
		OUT_SCAN,
		OUT_REQ
	} out_op_t;

	// controller to datapath
	typedef struct packed {
		logic       take;
		logic       place;
		logic [1:0] entry;
		logic       req_rd;
		out_op_t    out_op;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_room;
		logic is_last;
		logic sig_ok;
		logic place_stop;
	} dp_stat_t;

endpackage

// ===== hw/rtl/mbrlr_ctrl.sv =====
`timescale 1ns / 1ps
module mbrlr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_cmd,
	output logic                in_ready,
	input  mbrlr_pkg::dp_stat_t stat,
	output mbrlr_pkg::dp_cmd_t  cmd
);

	mbrlr_pkg::state_t state_q, state_d;
	logic [1:0] entry_q, entry_d;

	// state and entry counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbrlr_pkg::ST_IDLE;
			entry_q <= 2'd0;
		end else begin
			state_q <= state_d;
			entry_q <= entry_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		entry_d    = entry_q;
		in_ready   = 1'b0;
		cmd.take   = 1'b0;
		cmd.place  = 1'b0;
		cmd.entry  = entry_q;
		cmd.req_rd = 1'b0;
		cmd.out_op = mbrlr_pkg::OUT_NONE;
		case (state_q)
			mbrlr_pkg::ST_IDLE: begin
				in_ready = stat.out_room;
				if (in_valid && stat.out_room) begin
					cmd.take = 1'b1;
					case (in_cmd)
						mbrlr_pkg::CMD_BYTE: begin
							if (stat.is_last) begin
								if (stat.sig_ok) begin
									state_d = mbrlr_pkg::ST_PLACE;
									entry_d = 2'd0;
								end else begin
									cmd.out_op = mbrlr_pkg::OUT_BAD_SIG;
								end
							end
						end
						mbrlr_pkg::CMD_READ, mbrlr_pkg::CMD_WRITE: begin
							state_d = mbrlr_pkg::ST_REQ_RD;
						end
						default: begin
						end
					endcase
				end
			end
			mbrlr_pkg::ST_PLACE: begin
				cmd.place = 1'b1;
				if (stat.place_stop || entry_q == 2'd3) begin
					cmd.out_op = mbrlr_pkg::OUT_SCAN;
					state_d    = mbrlr_pkg::ST_IDLE;
				end else begin
					entry_d = entry_q + 2'd1;
				end
			end
			mbrlr_pkg::ST_REQ_RD: begin
				cmd.req_rd = 1'b1;
				state_d    = mbrlr_pkg::ST_REQ_CHK;
			end
			mbrlr_pkg::ST_REQ_CHK: begin
				cmd.out_op = mbrlr_pkg::OUT_REQ;
				state_d    = mbrlr_pkg::ST_IDLE;
			end
			default: begin
				state_d = mbrlr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/mbrlr_dp.sv =====
`timescale 1ns / 1ps
module mbrlr_dp #(
	parameter int SLOTS = mbrlr_pkg::SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [1:0]                        in_cmd,
	input  logic [7:0]                        record_byte,
	input  logic [3:0]                        slot,
	input  logic [63:0]                       rel_sector,
	input  logic [31:0]                       num_sectors,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,
	input  mbrlr_pkg::dp_cmd_t                cmd,
	output mbrlr_pkg::dp_stat_t               stat,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [mbrlr_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [0:0]                        m_tuser
);

	localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic        base_writable_q;
	logic [8:0]  pos_q;
	logic [7:0]  stg_type_q  [4];
	logic [31:0] stg_start_q [4];
	logic [31:0] stg_len_q   [4];
	logic [7:0]  sig_first_q;
	logic [SLOTS-1:0] in_use_q;
	logic [63:0] slot_mem [SLOTS];
	logic [63:0] rd_q;
	logic [2:0]  found_q;
	logic [3:0]  slot_q;
	logic [63:0] rel_q;
	logic [31:0] cnt_q;
	logic        wr_q;
	logic [64:0] sum_q;

	logic        m_tvalid_q;
	logic        out_ok_q;
	logic [2:0]  out_status_q;
	logic [2:0]  out_found_q;
	logic [63:0] out_abs_q;
	logic        out_kind_q;

	logic [8:0]  rel_pos;
	logic        in_entries;
	logic        take_byte;
	logic        have_free;
	logic [IdxW-1:0] free_idx;
	logic        eligible;
	logic        place_now;
	logic [2:0]  found_next;
	logic [IdxW-1:0] req_idx;
	logic        bad_slot;
	logic        slot_used;
	logic        out_range;
	logic [63:0] abs_sum;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_writable_q <= 1'b1;
		end else if (cfg_we) begin
			base_writable_q <= cfg_wdata;
		end
	end

	// byte position within the record
	assign take_byte  = cmd.take && (in_cmd == mbrlr_pkg::CMD_BYTE);
	assign rel_pos    = pos_q - mbrlr_pkg::ENTRY_BASE;
	assign in_entries = (pos_q >= mbrlr_pkg::ENTRY_BASE) && (pos_q < mbrlr_pkg::ENTRY_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 9'd0;
		end else if (take_byte) begin
			pos_q <= pos_q + 9'd1;
		end
	end

	// entry staging, little-endian fields
	always_ff @(posedge clk) begin
		if (take_byte) begin
			if (in_entries) begin
				if (rel_pos[3:0] == 4'd4) begin
					stg_type_q[rel_pos[5:4]] <= record_byte;
				end else if (rel_pos[3:2] == 2'b10) begin
					stg_start_q[rel_pos[5:4]][8*rel_pos[1:0] +: 8] <= record_byte;
				end else if (rel_pos[3:2] == 2'b11) begin
					stg_len_q[rel_pos[5:4]][8*rel_pos[1:0] +: 8] <= record_byte;
				end
			end else if (pos_q == mbrlr_pkg::SIG_POS) begin
				sig_first_q <= record_byte;
			end
		end
	end

	// lowest free slot
	always_comb begin
		have_free = 1'b0;
		free_idx  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				have_free = 1'b1;
				free_idx  = IdxW'(i);
			end
		end
	end

	assign eligible   = (stg_type_q[cmd.entry] != mbrlr_pkg::TYPE_EMPTY) &&
	                    (stg_len_q[cmd.entry] != 32'd0);
	assign place_now  = cmd.place && eligible && have_free;
	assign found_next = found_q + {2'b00, place_now};

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (place_now) begin
			in_use_q[free_idx] <= 1'b1;
		end
	end

	// found counter, cleared on each record byte taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 3'd0;
		end else if (take_byte) begin
			found_q <= 3'd0;
		end else if (cmd.place) begin
			found_q <= found_next;
		end
	end

	// slot table memory: {length, start}
	always_ff @(posedge clk) begin
		if (place_now) begin
			slot_mem[free_idx] <= {stg_len_q[cmd.entry], stg_start_q[cmd.entry]};
		end
	end

	assign req_idx = IdxW'(slot_q);

	always_ff @(posedge clk) begin
		if (cmd.req_rd) begin
			rd_q <= slot_mem[req_idx];
		end
	end

	// request capture and end sector sum
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			slot_q <= slot;
			rel_q  <= rel_sector;
			cnt_q  <= num_sectors;
			wr_q   <= (in_cmd == mbrlr_pkg::CMD_WRITE);
		end
		if (cmd.req_rd) begin
			sum_q <= {1'b0, rel_q} + {33'd0, cnt_q};
		end
	end

	// request checks
	assign bad_slot  = 32'(slot_q) >= SLOTS;
	assign slot_used = in_use_q[req_idx];
	assign out_range = sum_q > {33'd0, rd_q[63:32]};
	assign abs_sum   = {32'd0, rd_q[31:0]} + rel_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_op != mbrlr_pkg::OUT_NONE) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.out_op)
			mbrlr_pkg::OUT_BAD_SIG: begin
				out_kind_q   <= mbrlr_pkg::KIND_SCAN;
				out_ok_q     <= 1'b0;
				out_status_q <= mbrlr_pkg::ST_BAD_SIG;
				out_found_q  <= 3'd0;
				out_abs_q    <= 64'd0;
			end
			mbrlr_pkg::OUT_SCAN: begin
				out_kind_q   <= mbrlr_pkg::KIND_SCAN;
				out_ok_q     <= (found_next != 3'd0);
				out_status_q <= (found_next != 3'd0) ? mbrlr_pkg::ST_OK : mbrlr_pkg::ST_NONE;
				out_found_q  <= found_next;
				out_abs_q    <= 64'd0;
			end
			mbrlr_pkg::OUT_REQ: begin
				out_kind_q  <= mbrlr_pkg::KIND_ACCESS;
				out_found_q <= 3'd0;
				out_ok_q    <= 1'b0;
				out_abs_q   <= 64'd0;
				if (bad_slot) begin
					out_status_q <= mbrlr_pkg::ST_BAD_SLOT;
				end else if (!slot_used) begin
					out_status_q <= mbrlr_pkg::ST_UNUSED;
				end else if (out_range) begin
					out_status_q <= mbrlr_pkg::ST_RANGE;
				end else if (wr_q && !base_writable_q) begin
					out_status_q <= mbrlr_pkg::ST_RDONLY;
				end else begin
					out_status_q <= mbrlr_pkg::ST_OK;
					out_ok_q     <= 1'b1;
					out_abs_q    <= abs_sum;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_abs_q, out_found_q, out_status_q, out_ok_q};
	assign m_tuser  = out_kind_q;

	// status to the controller
	assign stat.out_room   = !m_tvalid_q || m_tready;
	assign stat.is_last    = (pos_q == mbrlr_pkg::RECORD_LAST);
	assign stat.sig_ok     = (sig_first_q == mbrlr_pkg::SIG_FIRST) &&
	                         (record_byte == mbrlr_pkg::SIG_SECOND);
	assign stat.place_stop = eligible && !have_free;

endmodule

// ===== hw/rtl/mbr_partition_map_and_lba_remap_unit.sv =====
`timescale 1ns / 1ps
// record bytes: one per cycle while the output has room, a result only after the last byte
// last byte: bad signature result in the next cycle, else placement of up to four
//   table entries (one table entry per cycle) and the scan result right after
// access requests: no new beat is taken until the result of the last one is registered,
//   which follows the registered slot table read and the range compare stage
// reset (async, active low) clears record position and slot valid bits, base_writable to 1
module mbr_partition_map_and_lba_remap_unit #(
	parameter int SLOTS = mbrlr_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input beats
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// record_byte[7:0], slot[11:8], rel_sector[75:12], num_sectors[107:76], zero pad
	input  logic [mbrlr_pkg::IN_DATA_W-1:0]  s_tdata,
	// cmd[1:0]
	input  logic [1:0]                       s_tuser,
	// result beats
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// ok[0], status[3:1], found[6:4], abs_sector[70:7], zero pad
	output logic [mbrlr_pkg::OUT_DATA_W-1:0] m_tdata,
	// kind[0]
	output logic [0:0]                       m_tuser,
	// base_writable register
	input  logic                             cfg_we,
	input  logic                             cfg_wdata
);

	mbrlr_pkg::dp_cmd_t  cmd;
	mbrlr_pkg::dp_stat_t stat;

	// sequencer
	mbrlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_cmd   (s_tuser),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// staging, slot table and checks
	mbrlr_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_cmd       (s_tuser),
		.record_byte  (s_tdata[7:0]),
		.slot         (s_tdata[11:8]),
		.rel_sector   (s_tdata[75:12]),
		.num_sectors  (s_tdata[107:76]),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.stat         (stat),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule

// ===== tb/mbr_remap_checker.sv =====
`timescale 1ns / 1ps
module mbr_remap_checker
	import mbrlr_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// record_byte, slot, rel_sector, num_sectors, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic [1:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// ok, status, found, abs_sector, zero pad
	input  logic [OUT_DATA_W-1:0] m_tdata,
	// kind
	input  logic [0:0]            m_tuser,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	output int                    fail_count,
	output int                    outstanding
);

	typedef struct packed {
		logic        kind;
		logic        ok;
		logic [2:0]  status;
		logic [2:0]  found;
		logic [63:0] abs_sector;
	} remap_result_t;

	// results still owed by the block, oldest first
	remap_result_t due_results[$];

	// own copy of the record staging and the partition table
	logic [8:0]  rec_pos = '0;
	logic [7:0]  ent_type [4];
	logic [31:0] ent_start [4];
	logic [31:0] ent_len [4];
	logic [7:0]  sig_lo = '0;
	logic        in_use [SLOTS];
	logic [31:0] map_start [SLOTS];
	logic [31:0] map_len [SLOTS];
	logic        writable = 1'b1;

	function automatic remap_result_t make_result(input logic kind, input logic ok,
			input logic [2:0] status, input logic [2:0] found, input logic [63:0] abs_sector);
		remap_result_t r;
		r.kind       = kind;
		r.ok         = ok;
		r.status     = status;
		r.found      = found;
		r.abs_sector = abs_sector;
		return r;
	endfunction

	// last byte: signature check, then fill the lowest free slots
	task automatic close_record(input logic [7:0] last_byte);
		int found;
		int free_slot;
		logic full;
		found = 0;
		full  = 1'b0;
		if (sig_lo != SIG_FIRST || last_byte != SIG_SECOND) begin
			due_results.push_back(make_result(KIND_SCAN, 1'b0, ST_BAD_SIG, 3'd0, 64'd0));
		end else begin
			for (int e = 0; e < 4; e++) begin
				if (!full && ent_type[e] != TYPE_EMPTY && ent_len[e] != 32'd0) begin
					free_slot = -1;
					for (int s = SLOTS - 1; s >= 0; s--)
						if (!in_use[s])
							free_slot = s;
					if (free_slot < 0) begin
						full = 1'b1;
					end else begin
						in_use[free_slot]    = 1'b1;
						map_start[free_slot] = ent_start[e];
						map_len[free_slot]   = ent_len[e];
						found++;
					end
				end
			end
			if (found == 0)
				due_results.push_back(make_result(KIND_SCAN, 1'b0, ST_NONE, 3'd0, 64'd0));
			else
				due_results.push_back(make_result(KIND_SCAN, 1'b1, ST_OK, found[2:0], 64'd0));
		end
	endtask

	// work out what one accepted beat should produce
	task automatic remap_predict(input logic [1:0] cmd, input logic [7:0] b, input logic [3:0] sl,
			input logic [63:0] rel, input logic [31:0] cnt);
		int pos;
		int e;
		int off;
		logic [63:0] span;
		case (cmd)
			CMD_BYTE: begin
				pos     = int'(rec_pos);
				rec_pos = rec_pos + 9'd1;
				if (pos == RECORD_LAST) begin
					close_record(b);
				end else if (pos >= ENTRY_BASE && pos < ENTRY_END) begin
					e   = (pos - ENTRY_BASE) / 16;
					off = (pos - ENTRY_BASE) % 16;
					if (off == 4)
						ent_type[e] = b;
					else if (off >= 8 && off < 12)
						ent_start[e][8 * (off - 8) +: 8] = b;
					else if (off >= 12)
						ent_len[e][8 * (off - 12) +: 8] = b;
				end else if (pos == SIG_POS) begin
					sig_lo = b;
				end
			end
			CMD_READ, CMD_WRITE: begin
				if (sl >= SLOTS) begin
					due_results.push_back(make_result(KIND_ACCESS, 1'b0, ST_BAD_SLOT, 3'd0, 64'd0));
				end else if (!in_use[sl]) begin
					due_results.push_back(make_result(KIND_ACCESS, 1'b0, ST_UNUSED, 3'd0, 64'd0));
				end else begin
					// exact range check, no wrap
					span = {32'd0, map_len[sl]};
					if (rel > span || {32'd0, cnt} > span - rel)
						due_results.push_back(make_result(KIND_ACCESS, 1'b0, ST_RANGE, 3'd0,
							64'd0));
					else if (cmd == CMD_WRITE && !writable)
						due_results.push_back(make_result(KIND_ACCESS, 1'b0, ST_RDONLY, 3'd0,
							64'd0));
					else
						due_results.push_back(make_result(KIND_ACCESS, 1'b1, ST_OK, 3'd0,
							{32'd0, map_start[sl]} + rel));
				end
			end
			default: begin
			end
		endcase
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin : watch
		remap_result_t got;
		remap_result_t want;
		if (!arst_n) begin
			rec_pos  = '0;
			sig_lo   = '0;
			writable = 1'b1;
			for (int e = 0; e < 4; e++) begin
				ent_type[e]  = '0;
				ent_start[e] = '0;
				ent_len[e]   = '0;
			end
			for (int s = 0; s < SLOTS; s++) begin
				in_use[s]    = 1'b0;
				map_start[s] = '0;
				map_len[s]   = '0;
			end
			due_results.delete();
		end else begin
			// result beat against the oldest expectation
			if (m_tvalid && m_tready) begin
				got = {m_tuser[0], m_tdata[0], m_tdata[3:1], m_tdata[6:4], m_tdata[70:7]};
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat: kind %0d ok %0d status %0d",
							got.kind, got.ok, got.status,
							" found %0d abs %h", got.found, got.abs_sector);
				end else begin
					want = due_results.pop_front();
					if (got.kind != want.kind || got.ok != want.ok || got.status != want.status ||
							got.found != want.found || got.abs_sector != want.abs_sector) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result mismatch: expected kind %0d ok %0d status %0d",
								want.kind, want.ok, want.status,
								" found %0d abs %h,", want.found, want.abs_sector,
								" got kind %0d ok %0d status %0d",
								got.kind, got.ok, got.status,
								" found %0d abs %h", got.found, got.abs_sector);
					end
				end
			end
			if (cfg_we)
				writable = cfg_wdata;
			if (s_tvalid && s_tready)
				remap_predict(s_tuser, s_tdata[7:0], s_tdata[11:8], s_tdata[75:12],
					s_tdata[107:76]);
		end
		outstanding = due_results.size();
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import mbrlr_pkg::*;

	localparam int SLOTS       = SLOTS_DEF;
	localparam int SETTLE      = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 25;
	localparam int ENTRY_SIZE  = 16;
	// command code the block ignores
	localparam logic [1:0] CMD_NONE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = CMD_BYTE;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_we = 1'b0;
	logic                  cfg_wdata = 1'b1;

	int fail_count;
	int outstanding;
	int quiet_cycles = 0;
	int n_sent = 0;
	int stall_asks = 0;
	logic steady = 1'b0;

	// entries of the next boot record, and what the table should now hold
	logic [7:0]  rec_type [4];
	logic [31:0] rec_start [4];
	logic [31:0] rec_len [4];
	logic [31:0] part_len [SLOTS];
	int          slots_taken = 0;

	always #1 clk = ~clk;

	mbr_partition_map_and_lba_remap_unit #(
		.SLOTS(SLOTS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	mbr_remap_checker #(
		.SLOTS(SLOTS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	// give up when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("mbr_partition_map_and_lba_remap_unit regression: fail");
			$finish;
		end
	end

	// result side: random backpressure, long hold-off on request
	initial begin : result_sink
		int holds_done;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (stall_asks != holds_done) begin
				holds_done = stall_asks;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= steady || ($urandom_range(0, 99) >= 17);
		end
	end

	// one beat on the input side, with random gaps before it
	task automatic offer(input logic [1:0] c, input logic [7:0] b, input logic [3:0] sl,
			input logic [63:0] rel, input logic [31:0] cnt);
		while (!steady && $urandom_range(0, 99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {{(IN_DATA_W - 108){1'b0}}, cnt, rel, sl, b};
		do
			@(posedge clk);
		while (!s_tready);
		n_sent++;
	endtask

	// stop offering and wait for every owed result
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_writable(input logic v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic put_entry(input int e, input logic [7:0] t, input logic [31:0] st,
			input logic [31:0] ln);
		rec_type[e]  = t;
		rec_start[e] = st;
		rec_len[e]   = ln;
	endtask

	// access request aimed near the partition bounds where the slot is in use
	task automatic send_request();
		logic [1:0]  c;
		logic [3:0]  sl;
		logic [63:0] rel;
		logic [31:0] cnt;
		logic [31:0] len;
		c   = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
		rel = {$urandom, $urandom};
		cnt = $urandom;
		if ($urandom_range(0, 9) == 0)
			sl = 4'($urandom_range(SLOTS, 15));
		else
			sl = 4'($urandom_range(0, SLOTS - 1));
		if (sl < slots_taken) begin
			len = part_len[sl];
			case ($urandom_range(0, 4))
				0: begin
					rel = {32'd0, $urandom_range(len, 0)};
					cnt = $urandom_range(len - rel[31:0], 0);
				end
				1: begin
					rel = {32'd0, $urandom_range(len, 0)};
					cnt = len - rel[31:0];
				end
				2: begin
					rel = {32'd0, $urandom_range(len, 0)};
					cnt = len - rel[31:0] + 32'd1;
				end
				3: begin
					rel = {32'd0, len};
					cnt = $urandom_range(1, 0);
				end
				default: begin
				end
			endcase
		end
		offer(c, 8'($urandom), sl, rel, cnt);
	endtask

	// a full boot record, with the odd request or ignored command mixed in
	task automatic send_record(input logic [7:0] sig0, input logic [7:0] sig1);
		logic [7:0] b;
		int e;
		int off;
		for (int p = 0; p <= RECORD_LAST; p++) begin
			if ($urandom_range(0, 99) < 3) begin
				if ($urandom_range(0, 3) == 0)
					offer(CMD_NONE, 8'($urandom), 4'($urandom), {$urandom, $urandom}, $urandom);
				else
					send_request();
			end
			b = 8'($urandom);
			if (p >= ENTRY_BASE && p < ENTRY_END) begin
				e   = (p - ENTRY_BASE) / ENTRY_SIZE;
				off = (p - ENTRY_BASE) % ENTRY_SIZE;
				if (off == 4)
					b = rec_type[e];
				else if (off >= 8 && off < 12)
					b = rec_start[e][8 * (off - 8) +: 8];
				else if (off >= 12)
					b = rec_len[e][8 * (off - 12) +: 8];
			end else if (p == SIG_POS) begin
				b = sig0;
			end else if (p == RECORD_LAST) begin
				b = sig1;
			end
			offer(CMD_BYTE, b, 4'($urandom), {$urandom, $urandom}, $urandom);
		end
		// track which slots now hold a partition, for request shaping
		if (sig0 == SIG_FIRST && sig1 == SIG_SECOND)
			for (int k = 0; k < 4; k++)
				if (rec_type[k] != TYPE_EMPTY && rec_len[k] != 32'd0 && slots_taken < SLOTS) begin
					part_len[slots_taken] = rec_len[k];
					slots_taken++;
				end
	endtask

	initial begin : stimulus
		int target;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_writable(1'b1);

		// requests against an empty table, and an ignored command
		offer(CMD_READ, 8'h00, 4'd0, 64'd0, 32'd0);
		offer(CMD_WRITE, 8'hFF, 4'd7, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		offer(CMD_READ, 8'h00, 4'd8, 64'd0, 32'd0);
		offer(CMD_WRITE, 8'h00, 4'd15, 64'd0, 32'd0);
		offer(CMD_NONE, 8'hFF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);

		// four partitions, extreme start and length among them
		put_entry(0, 8'h83, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		put_entry(1, 8'h01, 32'd0, 32'd1);
		put_entry(2, 8'h0C, $urandom, $urandom | 32'd1);
		put_entry(3, 8'hFF, $urandom, $urandom | 32'd1);
		send_record(SIG_FIRST, SIG_SECOND);

		// bounds of the first two slots
		offer(CMD_READ, 8'h00, 4'd0, 64'd0, 32'd0);
		offer(CMD_WRITE, 8'h00, 4'd0, 64'h0000_0000_FFFF_FFFF, 32'd0);
		offer(CMD_READ, 8'h00, 4'd0, 64'h0000_0001_0000_0000, 32'd0);
		offer(CMD_READ, 8'h00, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		offer(CMD_READ, 8'h00, 4'd1, 64'd0, 32'd1);
		offer(CMD_WRITE, 8'h00, 4'd1, 64'd1, 32'd0);
		offer(CMD_READ, 8'h00, 4'd1, 64'd1, 32'd1);
		offer(CMD_READ, 8'h00, 4'd1, 64'd0, 32'd2);
		offer(CMD_READ, 8'h00, 4'd4, 64'd0, 32'd0);

		// read-only base, and the order of the checks
		set_writable(1'b0);
		offer(CMD_WRITE, 8'h00, 4'd1, 64'd0, 32'd1);
		offer(CMD_WRITE, 8'h00, 4'd1, 64'd0, 32'd2);
		offer(CMD_WRITE, 8'h00, 4'd9, 64'd0, 32'd0);
		offer(CMD_READ, 8'h00, 4'd1, 64'd0, 32'd1);
		offer(CMD_WRITE, 8'h00, 4'd5, 64'd0, 32'd0);
		set_writable(1'b1);

		// two more partitions beside an empty and a zero-length entry, no idling
		put_entry(0, TYPE_EMPTY, $urandom, $urandom | 32'd1);
		put_entry(1, 8'h07, $urandom, $urandom | 32'd1);
		put_entry(2, 8'h05, $urandom, 32'd0);
		put_entry(3, 8'h0B, $urandom, $urandom | 32'd1);
		steady = 1'b1;
		send_record(SIG_FIRST, SIG_SECOND);
		steady = 1'b0;
		offer(CMD_READ, 8'h00, 4'd7, 64'd0, 32'd1);

		// random requests: hold-off phase, no-idle phase, plain phase
		for (int ph = 1; ph <= 3; ph++) begin
			set_writable((ph % 2 == 1) ? 1'b0 : 1'b1);
			steady = (ph == 2);
			if (ph == 1)
				stall_asks++;
			target = n_sent + PHASE_ITEMS;
			while (n_sent < target) begin
				if ($urandom_range(0, 19) == 0)
					offer(CMD_NONE, 8'($urandom), 4'($urandom), {$urandom, $urandom}, $urandom);
				else
					send_request();
			end
		end
		steady = 1'b0;

		drain();
		if (fail_count == 0 && outstanding == 0)
			$display("mbr_partition_map_and_lba_remap_unit regression: pass");
		else
			$display("mbr_partition_map_and_lba_remap_unit regression: fail");
		$finish;
	end

endmodule
